// File: rtl/core/assert_macros.svh
// Assertion macros shared by the encoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in every cycle out of reset
`define B64E_ASSERT_NOW(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("b64e assertion failed");

// Consequent must hold in the cycle after the antecedent
`define B64E_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64e assertion failed");

`endif

// File: rtl/core/b64e_pkg.sv
package b64e_pkg;

    // Padding character '='
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Characters produced for one input item, sent from chars[0] upward
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last;   // index of the last valid character
        logic            fin;    // item closes the message
    } t_run;

    // Map a 6-bit value onto the standard alphabet
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] c;
        w = {2'b00, v};
        case (v) inside
            [6'd0:6'd25]:  c = 8'h41 + w;
            [6'd26:6'd51]: c = 8'h61 + w - 8'd26;
            [6'd52:6'd61]: c = 8'h30 + w - 8'd52;
            6'd62:         c = 8'h2B;
            default:       c = 8'h2F;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/core/b64e_enc.sv
`include "assert_macros.svh"

module b64e_enc (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_byte,
    input  logic            i_fin,
    input  logic            i_ld,
    output b64e_pkg::t_run  o_run
);

    // Place within the current 3-byte group; the spare code is never reached
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2,
        PH_SPARE  = 2'd3
    } t_phase;

    t_phase     r_phase;
    logic [3:0] r_left;
    t_phase     n_phase;
    logic [3:0] n_left;
    logic [5:0] s0;
    logic [5:0] s1;

    // Sextets and next group state from current phase and byte
    always_comb begin
        s0          = 6'd0;
        s1          = 6'd0;
        n_phase     = PH_FIRST;
        n_left      = 4'd0;
        o_run.chars = {4{b64e_pkg::PAD_CHAR}};
        o_run.last  = 2'd0;
        o_run.fin   = i_fin;
        case (r_phase)
            PH_SECOND: begin
                s0      = {r_left[1:0], i_byte[7:4]};
                s1      = {i_byte[3:0], 2'b00};
                n_phase = PH_THIRD;
                n_left  = i_byte[3:0];
                o_run.chars[0] = b64e_pkg::sextet_char(s0);
                o_run.chars[1] = b64e_pkg::sextet_char(s1);
                o_run.last     = i_fin ? 2'd2 : 2'd0;
            end
            PH_THIRD: begin
                s0      = {r_left, i_byte[7:6]};
                s1      = i_byte[5:0];
                n_phase = PH_FIRST;
                n_left  = 4'd0;
                o_run.chars[0] = b64e_pkg::sextet_char(s0);
                o_run.chars[1] = b64e_pkg::sextet_char(s1);
                o_run.last     = 2'd1;
            end
            default: begin
                // start of group; the unreachable spare phase lands here too
                s0      = i_byte[7:2];
                s1      = {i_byte[1:0], 4'b0000};
                n_phase = PH_SECOND;
                n_left  = {2'b00, i_byte[1:0]};
                o_run.chars[0] = b64e_pkg::sextet_char(s0);
                o_run.chars[1] = b64e_pkg::sextet_char(s1);
                o_run.last     = i_fin ? 2'd3 : 2'd0;
            end
        endcase
        // final byte closes the group
        if (i_fin) begin
            n_phase = PH_FIRST;
            n_left  = 4'd0;
        end
    end

    // Group state, advanced once per loaded item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_left  <= 4'd0;
        end else if (i_ld) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

    `B64E_ASSERT_NOW(a_phase_legal, i_clk, i_rst_n, r_phase != PH_SPARE)
    `B64E_ASSERT_NEXT(a_fin_clears, i_clk, i_rst_n, i_ld && i_fin, r_phase == PH_FIRST && r_left == 4'd0)
    `B64E_ASSERT_NOW(a_left_clear, i_clk, i_rst_n, r_phase != PH_FIRST || r_left == 4'd0)

endmodule

// File: rtl/core/b64e_ser.sv
`include "assert_macros.svh"

module b64e_ser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_ld,
    input  b64e_pkg::t_run  i_run,
    output logic            o_free,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_out_char,
    output logic            o_run_end,
    output logic            o_message_end
);

    logic            r_valid;
    logic [3:0][7:0] r_chars;
    logic [1:0]      r_left;
    logic            r_fin;
    logic            take;
    logic            last;

    assign take = r_valid && i_out_ready;
    assign last = (r_left == 2'd0);

    // Buffer can take a new run once the last character leaves
    assign o_free = !r_valid || (take && last);

    assign o_out_valid   = r_valid;
    assign o_out_char    = r_chars[0];
    assign o_run_end     = last;
    assign o_message_end = last && r_fin;

    // Occupancy and remaining count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= 2'd0;
        end else if (i_ld) begin
            r_valid <= 1'b1;
            r_left  <= i_run.last;
        end else if (take) begin
            if (last) begin
                r_valid <= 1'b0;
            end else begin
                r_left <= r_left - 2'd1;
            end
        end
    end

    // Character shift line, payload only
    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_chars <= i_run.chars;
            r_fin   <= i_run.fin;
        end else if (take) begin
            r_chars <= {8'h00, r_chars[3:1]};
        end
    end

    `B64E_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, !i_ld || !r_valid || (take && last))
    `B64E_ASSERT_NEXT(a_hold_stall, i_clk, i_rst_n,
                      r_valid && !i_out_ready && !i_ld, r_valid && $stable(r_left))
    `B64E_ASSERT_NEXT(a_ld_valid, i_clk, i_rst_n, i_ld, r_valid)

endmodule

// File: rtl/core/base64_stream_encoder.sv
// Channel   Direction  Handshake                   Payload
// in        input      i_in_valid / o_in_ready     i_data_byte, i_final_byte
// out       output     o_out_valid / i_out_ready   o_out_char, o_run_end, o_message_end
//
// One character leaves per cycle while i_out_ready is high; an item yields
// 1 to 4 characters, so a 3-byte group yields 4 characters (2 on its third
// byte). The first character is presented from the character buffer, which
// an accepted item reaches by way of the input register.
// Reset is synchronous, active low, and returns to the start of a group.
// An output stall holds the current character; the input register still
// takes one more item while the output waits.
module base64_stream_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_char,
    output logic       o_run_end,
    output logic       o_message_end
);

    logic           r_in_valid;
    logic [7:0]     r_in_byte;
    logic           r_in_fin;
    logic           ser_free;
    logic           ld;
    b64e_pkg::t_run run;

    // Item moves into the character buffer when that buffer frees up
    assign ld         = r_in_valid && ser_free;
    assign o_in_ready = !r_in_valid || ld;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_fin  <= i_final_byte;
        end
    end

    b64e_enc u_enc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (r_in_byte),
        .i_fin   (r_in_fin),
        .i_ld    (ld),
        .o_run   (run)
    );

    b64e_ser u_ser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ld          (ld),
        .i_run         (run),
        .o_free        (ser_free),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_char    (o_out_char),
        .o_run_end     (o_run_end),
        .o_message_end (o_message_end)
    );

endmodule
